// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, quiet during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/buioc_pkg.sv -----
package buioc_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 256;
    localparam int ID_W    = 29;
    localparam int COUNT_W = 32;
    localparam int INDEX_W = 8;
    localparam int TOTAL_W = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic {
        CMD_OBSERVE = 1'b0,
        CMD_READ    = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } seq_state_t;

    // One table slot as it travels along the ring
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [ID_W-1:0]    frame_id;
        logic [INDEX_W-1:0] entry_index;
    } in_item_t;

    typedef struct packed {
        logic               hit;
        logic               inserted;
        logic               dropped;
        logic [INDEX_W-1:0] slot;
        logic               entry_valid;
        logic [ID_W-1:0]    entry_id;
        logic [COUNT_W-1:0] entry_count;
        logic [TOTAL_W-1:0] unique_total;
        logic [COUNT_W-1:0] frame_total;
    } out_item_t;

    // Saturating increment of a count
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

endpackage

// ----- src/bus_id_occurrence_counter.sv -----
// Frame identifier occurrence table. Slots live in a ring of TABLE_DEPTH
// cells that turns once per transaction, so each slot passes the head cell
// exactly once, in slot order, where it is compared, counted, appended or
// read out. A transaction is accepted in the idle state, walks the ring in
// the scan state, and waits in the hold state until the output register
// frees up and takes its result; the next transaction is accepted in the
// cycle after the result is loaded, even while that result still waits to
// be taken. Slot contents are not cleared at reset; only slots below the
// unique total are ever consulted.
module bus_id_occurrence_counter #(
    parameter int TABLE_DEPTH = buioc_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  buioc_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output buioc_pkg::out_item_t out_data
);

    buioc_pkg::entry_t cell_q [TABLE_DEPTH];
    buioc_pkg::entry_t tail;
    logic              shift;

    // Walk the slots through the head and back into the tail
    buioc_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .head      (cell_q[0]),
        .tail      (tail),
        .shift     (shift)
    );

    // Chain the cells into a ring
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        if (i == TABLE_DEPTH - 1)
        begin : g_last
            buioc_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .nbr   (tail),
                .q     (cell_q[i])
            );
        end
        else
        begin : g_mid
            buioc_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .nbr   (cell_q[i+1]),
                .q     (cell_q[i])
            );
        end
    end

endmodule

// ----- src/buioc_cell.sv -----
module buioc_cell (
    input  logic              clk,
    input  logic              shift,
    input  buioc_pkg::entry_t nbr,
    output buioc_pkg::entry_t q
);

    buioc_pkg::entry_t q_reg;

    // Take the neighbor's slot on every ring step
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= nbr;
        end
    end

    assign q = q_reg;

endmodule

// ----- src/buioc_seq.sv -----
module buioc_seq #(
    parameter int TABLE_DEPTH = buioc_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  buioc_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output buioc_pkg::out_item_t out_data,
    input  buioc_pkg::entry_t    head,
    output buioc_pkg::entry_t    tail,
    output logic                 shift
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);

    buioc_pkg::seq_state_t state_reg, state_next;
    logic [IDX_W-1:0]      step_reg, step_next;
    logic [USED_W-1:0]     used_reg, used_next;
    logic [buioc_pkg::COUNT_W-1:0] frames_reg, frames_next;
    logic                  found_reg, found_next;
    buioc_pkg::in_item_t   item_reg, item_next;
    buioc_pkg::out_item_t  res_reg, res_next;
    buioc_pkg::out_item_t  out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  below_used;
    logic                  at_used;
    logic                  last_step;
    logic [buioc_pkg::COUNT_W-1:0] bumped;

    assign below_used = 32'(step_reg) < 32'(used_reg);
    assign at_used    = 32'(step_reg) == 32'(used_reg);
    assign last_step  = step_reg == IDX_W'(TABLE_DEPTH - 1);
    assign bumped     = buioc_pkg::sat_inc(head.count);

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= buioc_pkg::ST_IDLE;
            step_reg      <= '0;
            used_reg      <= '0;
            frames_reg    <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            used_reg      <= used_next;
            frames_reg    <= frames_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // Sequence one transaction over a full turn of the ring
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        used_next      = used_reg;
        frames_next    = frames_reg;
        found_next     = found_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        tail           = head;
        shift          = 1'b0;
        in_ready       = 1'b0;

        // Drop the output once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            buioc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next  = in_data;
                    step_next  = '0;
                    found_next = 1'b0;
                    res_next   = '0;
                    if (in_data.cmd == buioc_pkg::CMD_OBSERVE)
                    begin
                        frames_next = buioc_pkg::sat_inc(frames_reg);
                    end
                    else
                    begin
                        res_next.slot        = in_data.entry_index;
                        res_next.entry_valid = 32'(in_data.entry_index) < 32'(used_reg);
                    end
                    state_next = buioc_pkg::ST_SCAN;
                end
            end

            buioc_pkg::ST_SCAN:
            begin
                shift = 1'b1;
                if (item_reg.cmd == buioc_pkg::CMD_OBSERVE)
                begin
                    if (!found_reg && below_used && head.id == item_reg.frame_id)
                    begin
                        // Count a known identifier
                        tail.count           = bumped;
                        found_next           = 1'b1;
                        res_next.hit         = 1'b1;
                        res_next.slot        = 8'(step_reg);
                        res_next.entry_id    = item_reg.frame_id;
                        res_next.entry_count = bumped;
                    end
                    else if (!found_reg && at_used)
                    begin
                        // Append into the first free slot
                        tail.id              = item_reg.frame_id;
                        tail.count           = buioc_pkg::COUNT_W'(1);
                        found_next           = 1'b1;
                        used_next            = used_reg + USED_W'(1);
                        res_next.inserted    = 1'b1;
                        res_next.slot        = 8'(step_reg);
                        res_next.entry_id    = item_reg.frame_id;
                        res_next.entry_count = buioc_pkg::COUNT_W'(1);
                    end
                end
                else if (res_reg.entry_valid &&
                         32'(step_reg) == 32'(item_reg.entry_index))
                begin
                    res_next.entry_id    = head.id;
                    res_next.entry_count = head.count;
                end
                step_next = step_reg + IDX_W'(1);
                if (last_step)
                begin
                    state_next = buioc_pkg::ST_HOLD;
                end
            end

            buioc_pkg::ST_HOLD:
            begin
                // Move the result out once the output register frees up
                if (!out_valid_reg || out_ready)
                begin
                    out_next              = res_reg;
                    out_next.dropped      = (item_reg.cmd == buioc_pkg::CMD_OBSERVE) &&
                                            !found_reg;
                    out_next.unique_total = 9'(used_reg);
                    out_next.frame_total  = frames_reg;
                    out_valid_next        = 1'b1;
                    state_next            = buioc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = buioc_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- src/buioc_checker.sv -----
`include "assert_macros.svh"

module buioc_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input buioc_pkg::out_item_t out_data
);

    logic [2:0] outcome;

    // Gather the observe outcome flags
    assign outcome = {out_data.hit, out_data.inserted, out_data.dropped};

    // At most one observe outcome per result
    `ASSERT_IMPLIES(a_one_outcome, clk, rst_n, out_valid, $onehot0(outcome))

    // A valid read carries no observe outcome
    `ASSERT_IMPLIES(a_read_clean, clk, rst_n, out_valid && out_data.entry_valid, outcome == 3'b000)

    // A fresh slot starts with a count of one
    `ASSERT_IMPLIES(a_insert_one, clk, rst_n, out_valid && out_data.inserted, out_data.entry_count == 32'd1)

    // One transaction at a time through the ring
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // A stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind bus_id_occurrence_counter buioc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
